// File: hw/rtl/scmb_pkg.sv
package scmb_pkg;

  localparam int WORD_W           = 64;
  localparam int NUM_COUNTERS_DEF = 64;
  localparam int MAX_RANGE        = 64;

  localparam int CMD_W     = 3;
  localparam int IDX_IN_W  = 7;
  localparam int CNT_IN_W  = 7;
  localparam int PROC_W    = 7;
  localparam int RES_IDX_W = 6;
  localparam int SEL_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 208;
  localparam int OUT_TUSER_W = 2;

  localparam logic [SEL_W-1:0] PKTS_SEL_RST  = SEL_W'(2);
  localparam logic [SEL_W-1:0] BYTES_SEL_RST = SEL_W'(3);

  // rate arithmetic: divide by the sample period, bytes to bits by shift
  localparam int DIVISOR    = 10;
  localparam int BIT_SHIFT  = 3;
  localparam int RATE_LANES = 2;
  localparam int LANE_PKT   = 0;
  localparam int LANE_BIT   = 1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RATE_LANES-1:0][WORD_W-1:0] rate_pair_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_INC       = 3'd1,
    CMD_DEC       = 3'd2,
    CMD_READ      = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_CLEAR_ALL = 3'd5,
    CMD_RATE      = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PKTS_SEL  = 1'b0,
    CFG_BYTES_SEL = 1'b1
  } cfg_reg_t;

endpackage

// File: hw/rtl/scmb_ram.sv
module scmb_ram #(
  parameter int DEPTH  = scmb_pkg::NUM_COUNTERS_DEF,
  parameter int ADDR_W = $clog2(scmb_pkg::NUM_COUNTERS_DEF)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  scmb_pkg::word_t    wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output scmb_pkg::word_t    rdata
);
  import scmb_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/scmb_div10.sv
module scmb_div10 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  scmb_pkg::rate_pair_t dividend,
  output scmb_pkg::rate_pair_t quotient,
  output logic                 done
);
  import scmb_pkg::*;

  localparam int STEP_W    = 3;
  localparam int LAST_STEP = 5;
  localparam int REM_W     = 5;
  localparam logic [REM_W-1:0] REM_MAX = REM_W'(DIVISOR - 1);

  rate_pair_t                          q;
  rate_pair_t                          q_first;
  rate_pair_t                          q_next;
  rate_pair_t                          n;
  logic [RATE_LANES-1:0][REM_W-1:0]    r_low;
  logic                                busy;
  logic [STEP_W-1:0]                   step;

  // divide by ten as x * 0.8 / 8: build x * 0.8 from shifted adds, one add per step,
  // then shift down by three and bump the quotient when it came out one short
  always_comb begin
    for (int l = 0; l < RATE_LANES; l++) begin
      q_first[l] = (dividend[l] >> 1) + (dividend[l] >> 2);
      // low bits of x - 10q are enough: the remainder before the fix is below 20
      r_low[l] = n[l][REM_W-1:0] - (q[l][REM_W-1:0] << 3) - (q[l][REM_W-1:0] << 1);
      case (step)
        3'd0:    q_next[l] = q[l] + (q[l] >> 4);
        3'd1:    q_next[l] = q[l] + (q[l] >> 8);
        3'd2:    q_next[l] = q[l] + (q[l] >> 16);
        3'd3:    q_next[l] = q[l] + (q[l] >> 32);
        3'd4:    q_next[l] = q[l] >> 3;
        default: q_next[l] = q[l] + word_t'(r_low[l] > REM_MAX);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(LAST_STEP)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= q_first;
      n <= dividend;
    end else if (busy) begin
      q <= q_next;
    end
  end

  assign quotient = q;

endmodule

// File: hw/rtl/statistics_counter_bank_core.sv
// Sequence: add, inc and dec read the counter, then write it back and report; range clear
//   and clear all sweep their counters first; a range read gives one result per cycle while
//   the output is free; a rate update reads both counters, then runs the six-step
//   shift-and-add divide by ten only when both counts grew. Items are taken one at a time.
// Reset: sync, active high; a sweep over all NUM_COUNTERS entries zeroes the memory with
//   s_axis_tready low; configuration writes are taken during the sweep.
module statistics_counter_bank_core #(
  parameter int NUM_COUNTERS = scmb_pkg::NUM_COUNTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tdata: counter_index[6:0], range_count[13:7], add_value[77:14], zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [scmb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: cmd[2:0]
  input  logic [scmb_pkg::CMD_W-1:0]          s_axis_tuser,
  // m_axis_tdata: result_index[5:0], counter_value[69:6], processed_count[76:70],
  //               packet_rate[140:77], bit_rate[204:141], zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [scmb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // m_axis_tuser: status[0], value_valid[1]
  output logic [scmb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [scmb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scmb_pkg::SEL_W-1:0]          cfg_data
);
  import scmb_pkg::*;

  localparam int IDX_W = $clog2(NUM_COUNTERS);
  localparam int REM_W = $clog2(NUM_COUNTERS + 1);
  // compare width: covers the 7-bit inputs, their sum and the bank size
  localparam int CMP_W = IDX_W + 8;
  localparam logic [CMP_W-1:0]  BANK_SIZE      = CMP_W'(NUM_COUNTERS);
  localparam logic [CNT_IN_W-1:0] RANGE_LIMIT  = CNT_IN_W'(MAX_RANGE);
  localparam logic [PROC_W-1:0] CLEAR_ALL_PROC =
    PROC_W'((NUM_COUNTERS > MAX_RANGE) ? MAX_RANGE : NUM_COUNTERS);
  localparam int OUT_USED_W = RES_IDX_W + WORD_W + PROC_W + 2 * WORD_W;

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,  // reset sweep
    S_IDLE = 9'b000000010,
    S_UPD  = 9'b000000100,  // read data back, write updated counter
    S_RD   = 9'b000001000,  // range read, one counter per cycle while the output is free
    S_CLR  = 9'b000010000,  // range clear / clear all sweep
    S_RP   = 9'b000100000,  // packet counter read returns
    S_RB   = 9'b001000000,  // byte counter read returns
    S_DIV  = 9'b010000000,  // waiting on divide by ten
    S_RESP = 9'b100000000   // single summary result
  } state_t;

  state_t state, state_next;

  // input fields
  cmd_t                  in_cmd;
  logic [IDX_IN_W-1:0]   in_idx;
  logic [CNT_IN_W-1:0]   in_cnt;
  word_t                 in_add;
  logic                  in_acc;
  logic [CMP_W-1:0]      idx_wide;
  logic [CMP_W-1:0]      cnt_wide;
  logic                  idx_bad;
  logic                  range_bad;
  logic                  acc_err;
  logic [PROC_W-1:0]     acc_proc;

  // sequencer state
  logic [IDX_W-1:0]      cur;
  logic [CMP_W-1:0]      cur_wide;
  logic [REM_W-1:0]      rem;
  logic [PROC_W-1:0]     proc;
  word_t                 upd_operand;
  logic                  resp_status;
  logic [PROC_W-1:0]     resp_proc;

  // rate update state
  logic [SEL_W-1:0]      pkts_sel;
  logic [SEL_W-1:0]      bytes_sel;
  logic [CMP_W-1:0]      pkts_wide;
  logic [CMP_W-1:0]      bytes_wide;
  logic                  pkts_ok;
  logic                  bytes_ok;
  word_t                 p_now;
  word_t                 b_now;
  word_t                 p_snap;
  word_t                 b_snap;
  word_t                 b_delta;
  word_t                 prate;
  word_t                 brate;
  logic                  grown;
  rate_pair_t            div_in;
  rate_pair_t            div_quot;
  logic                  div_start;
  logic                  div_done;

  // counter memory ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  word_t                 ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  word_t                 ram_rdata;

  // output register
  logic                  out_free;
  logic                  out_load;
  logic                  o_status;
  logic                  o_valid;
  logic [RES_IDX_W-1:0]  o_index;
  word_t                 o_value;
  logic [PROC_W-1:0]     o_proc;
  word_t                 o_prate;
  word_t                 o_brate;
  logic                  o_last;

  // unpack the input item
  assign in_cmd = cmd_t'(s_axis_tuser);
  assign in_idx = s_axis_tdata[IDX_IN_W-1:0];
  assign in_cnt = s_axis_tdata[IDX_IN_W +: CNT_IN_W];
  assign in_add = s_axis_tdata[IDX_IN_W + CNT_IN_W +: WORD_W];

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign idx_wide   = CMP_W'(in_idx);
  assign cnt_wide   = CMP_W'(in_cnt);
  assign cur_wide   = CMP_W'(cur);
  assign pkts_wide  = CMP_W'(pkts_sel);
  assign bytes_wide = CMP_W'(bytes_sel);

  assign idx_bad   = idx_wide >= BANK_SIZE;
  assign range_bad = (in_cnt > RANGE_LIMIT) || ((idx_wide + cnt_wide) > BANK_SIZE);
  // a rate register that points past the bank reads as zero
  assign pkts_ok   = pkts_wide < BANK_SIZE;
  assign bytes_ok  = bytes_wide < BANK_SIZE;

  // status and count for the summary result of this item
  always_comb begin
    acc_err  = 1'b0;
    acc_proc = '0;
    case (in_cmd)
      CMD_ADD, CMD_INC, CMD_DEC: acc_err = idx_bad;
      CMD_READ:                  acc_err = range_bad;
      CMD_CLEAR: begin
        acc_err  = range_bad;
        acc_proc = range_bad ? '0 : in_cnt;
      end
      CMD_CLEAR_ALL:             acc_proc = CLEAR_ALL_PROC;
      CMD_RATE:                  acc_err = 1'b0;
      default:                   acc_err = 1'b1;
    endcase
  end

  // rate math on the byte counter as it comes back from memory
  assign b_now   = bytes_ok ? ram_rdata : '0;
  assign grown   = (p_now > p_snap) && (b_now > b_snap);
  assign b_delta = b_now - b_snap;
  assign div_in[LANE_PKT] = p_now - p_snap;
  assign div_in[LANE_BIT] = b_delta << BIT_SHIFT;

  // sequencer: memory port control and next state
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cur;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cur;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_INIT: begin
        ram_we = 1'b1;
        if (rem == REM_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_ADD, CMD_INC, CMD_DEC: begin
              if (idx_bad) begin
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = idx_wide[IDX_W-1:0];
                state_next = S_UPD;
              end
            end
            CMD_READ: begin
              if (range_bad || in_cnt == '0) begin
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = idx_wide[IDX_W-1:0];
                state_next = S_RD;
              end
            end
            CMD_CLEAR: begin
              state_next = (range_bad || in_cnt == '0) ? S_RESP : S_CLR;
            end
            CMD_CLEAR_ALL: state_next = S_CLR;
            CMD_RATE: begin
              ram_re     = 1'b1;
              ram_raddr  = pkts_wide[IDX_W-1:0];
              state_next = S_RP;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_UPD: begin
        // write back and report in the same cycle; hold while the output is full
        if (out_free) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata + upd_operand;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rem == REM_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cur + IDX_W'(1);
          end
        end
      end
      S_CLR: begin
        ram_we = 1'b1;
        if (rem == REM_W'(1)) begin
          state_next = S_RESP;
        end
      end
      S_RP: begin
        ram_re     = 1'b1;
        ram_raddr  = bytes_wide[IDX_W-1:0];
        state_next = S_RB;
      end
      S_RB: begin
        if (grown) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_RESP;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state, configuration and stored rates
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      cur           <= '0;
      rem           <= REM_W'(NUM_COUNTERS);
      m_axis_tvalid <= 1'b0;
      pkts_sel      <= PKTS_SEL_RST;
      bytes_sel     <= BYTES_SEL_RST;
      p_snap        <= '0;
      b_snap        <= '0;
      prate         <= '0;
      brate         <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_PKTS_SEL:  pkts_sel  <= cfg_data;
          CFG_BYTES_SEL: bytes_sel <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_INIT, S_CLR: begin
          // advance the sweep one entry per cycle
          cur <= cur + IDX_W'(1);
          rem <= rem - REM_W'(1);
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_cmd == CMD_CLEAR_ALL) begin
              cur <= '0;
              rem <= REM_W'(NUM_COUNTERS);
            end else begin
              cur <= idx_wide[IDX_W-1:0];
              rem <= cnt_wide[REM_W-1:0];
            end
          end
        end
        S_RD: begin
          if (out_free) begin
            cur <= cur + IDX_W'(1);
            rem <= rem - REM_W'(1);
          end
        end
        S_RB: begin
          // take new snapshots; drop the rates unless both counts grew
          p_snap <= p_now;
          b_snap <= b_now;
          if (!grown) begin
            prate <= '0;
            brate <= '0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            prate <= div_quot[LANE_PKT];
            brate <= div_quot[LANE_BIT];
          end
        end
        default: ;
      endcase
    end
  end

  // per-item payload: operand, summary result, read progress, packet sample
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      resp_status <= acc_err;
      resp_proc   <= acc_proc;
      proc        <= '0;
      case (in_cmd)
        CMD_ADD: upd_operand <= in_add;
        CMD_INC: upd_operand <= word_t'(1);
        default: upd_operand <= '1;  // decrement adds all ones
      endcase
    end
    if (state == S_RD && out_free) begin
      proc <= proc + PROC_W'(1);
    end
    if (state == S_RP) begin
      p_now <= pkts_ok ? ram_rdata : '0;
    end
  end

  // output register: counter values on range reads, otherwise a summary result
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status <= (state == S_RESP) ? resp_status : 1'b0;
      o_valid  <= (state == S_RD);
      o_index  <= (state == S_RD) ? cur_wide[RES_IDX_W-1:0] : '0;
      o_value  <= (state == S_RD) ? ram_rdata : '0;
      o_last   <= (state == S_RD) ? (rem == REM_W'(1)) : 1'b1;
      o_prate  <= prate;
      o_brate  <= brate;
      case (state)
        S_RD:    o_proc <= proc + PROC_W'(1);
        S_RESP:  o_proc <= resp_proc;
        default: o_proc <= '0;
      endcase
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                         o_brate, o_prate, o_proc, o_value, o_index};
  assign m_axis_tuser = {o_valid, o_status};
  assign m_axis_tlast = o_last;

  scmb_ram #(
    .DEPTH  (NUM_COUNTERS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scmb_div10 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .quotient (div_quot),
    .done     (div_done)
  );

  // no memory write while waiting for an item
  ap_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("counter memory written while idle");

  // an out-of-range or unknown item gives one result only
  ap_err_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("error result not marked last");

  // one item at a time: no accept right after an accept
  ap_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("item accepted while previous item in progress");

  // divider start leads into the divide wait
  ap_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIV))
    else $error("divider started outside rate update");

endmodule

// File: tb/tb_statistics_counter_bank_core.sv
`timescale 1ns / 100ps

module tb_statistics_counter_bank_core;
  import scmb_pkg::*;

  localparam int NCNT = NUM_COUNTERS_DEF;
  // Command code 7 has no enum member; the block must reject it.
  localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;
  localparam int CYCLE_LIMIT = 4_000_000;
  // Hold-off at the end: longer than the slowest rate update.
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_CAP = 40;
  localparam int ITEMS_PER_PHASE = 170;

  // One command item as it travels on the slave side.
  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic [IDX_IN_W-1:0] idx;
    logic [CNT_IN_W-1:0] cnt;
    word_t               amount;
  } stat_cmd_t;

  // One result item as it travels on the master side.
  typedef struct packed {
    logic                 status;
    logic                 value_valid;
    logic [RES_IDX_W-1:0] index;
    word_t                value;
    logic [PROC_W-1:0]    processed;
    word_t                pkt_rate;
    word_t                bit_rate;
    logic                 last;
  } stat_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // s_axis_tdata: counter_index[6:0], range_count[13:7], add_value[77:14], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // s_axis_tuser: cmd[2:0]
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // m_axis_tdata: result_index[5:0], counter_value[69:6], processed_count[76:70],
  //               packet_rate[140:77], bit_rate[204:141], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // m_axis_tuser: status[0], value_valid[1]
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SEL_W-1:0]       cfg_data = '0;

  statistics_counter_bank_core #(
    .NUM_COUNTERS(NCNT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the counter bank, the rate snapshots and the selector registers.
  word_t            counter_mirror [NCNT];
  word_t            pkt_snap;
  word_t            byte_snap;
  word_t            pkt_rate;
  word_t            bit_rate;
  logic [SEL_W-1:0] pkts_sel = PKTS_SEL_RST;
  logic [SEL_W-1:0] bytes_sel = BYTES_SEL_RST;

  stat_cmd_t cmd_pending_q [$];
  stat_rsp_t rsp_expected_q [$];

  int  n_queued = 0;
  int  n_taken = 0;
  int  n_results = 0;
  int  err_count = 0;
  int  cycle_count = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  in_fire = 1'b0;

  stat_cmd_t next_cmd;
  stat_cmd_t seen_cmd;
  stat_rsp_t seen_rsp;
  stat_rsp_t want_rsp;

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t ns result %0d: %s got %h want %h", $time, n_results, what, got, want);
  endtask

  // Append one expected result; the rates are whatever the mirror holds right now.
  task automatic push_rsp(input logic status, input logic valid,
                          input logic [RES_IDX_W-1:0] index, input word_t value,
                          input logic [PROC_W-1:0] processed, input logic last);
    stat_rsp_t r;
    r.status      = status;
    r.value_valid = valid;
    r.index       = index;
    r.value       = value;
    r.processed   = processed;
    r.pkt_rate    = pkt_rate;
    r.bit_rate    = bit_rate;
    r.last        = last;
    rsp_expected_q.push_back(r);
  endtask

  // Apply one accepted command to the mirror and queue the results it causes.
  task automatic predict_counter_op(input stat_cmd_t c);
    word_t pnow;
    word_t bnow;
    word_t dbits;
    int    first;
    int    span;
    first = int'(c.idx);
    span  = int'(c.cnt);
    case (c.op)
      CMD_ADD, CMD_INC, CMD_DEC: begin
        if (first >= NCNT) begin
          push_rsp(1'b1, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          if (c.op == CMD_ADD)
            counter_mirror[first] = counter_mirror[first] + c.amount;
          else if (c.op == CMD_INC)
            counter_mirror[first] = counter_mirror[first] + word_t'(1);
          else
            counter_mirror[first] = counter_mirror[first] - word_t'(1);
          push_rsp(1'b0, 1'b0, '0, '0, '0, 1'b1);
        end
      end
      CMD_READ, CMD_CLEAR: begin
        if (span > MAX_RANGE || first + span > NCNT) begin
          push_rsp(1'b1, 1'b0, '0, '0, '0, 1'b1);
        end else if (c.op == CMD_CLEAR) begin
          for (int i = 0; i < span; i++) counter_mirror[first + i] = '0;
          push_rsp(1'b0, 1'b0, '0, '0, PROC_W'(span), 1'b1);
        end else if (span == 0) begin
          push_rsp(1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < span; i++)
            push_rsp(1'b0, 1'b1, RES_IDX_W'(first + i), counter_mirror[first + i],
                     PROC_W'(i + 1), (i + 1 == span));
        end
      end
      CMD_CLEAR_ALL: begin
        foreach (counter_mirror[k]) counter_mirror[k] = '0;
        push_rsp(1'b0, 1'b0, '0, '0, PROC_W'((NCNT > MAX_RANGE) ? MAX_RANGE : NCNT), 1'b1);
      end
      CMD_RATE: begin
        pnow = counter_mirror[pkts_sel];
        bnow = counter_mirror[bytes_sel];
        // Zero both rates unless both counts moved up since the last snapshot.
        if (pnow <= pkt_snap || bnow <= byte_snap) begin
          pkt_rate = '0;
          bit_rate = '0;
        end else begin
          pkt_rate = (pnow - pkt_snap) / word_t'(DIVISOR);
          dbits    = (bnow - byte_snap) << BIT_SHIFT;
          bit_rate = dbits / word_t'(DIVISOR);
        end
        pkt_snap  = pnow;
        byte_snap = bnow;
        push_rsp(1'b0, 1'b0, '0, '0, '0, 1'b1);
      end
      default: begin
        push_rsp(1'b1, 1'b0, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  function automatic stat_cmd_t make_cmd(input logic [CMD_W-1:0] op, input int idx,
                                         input int cnt, input word_t amount);
    stat_cmd_t c;
    c.op     = op;
    c.idx    = IDX_IN_W'(idx);
    c.cnt    = CNT_IN_W'(cnt);
    c.amount = amount;
    return c;
  endfunction

  // Random command, biased so that the rate counters grow between rate updates
  // and most ranges are short and in bounds.
  function automatic stat_cmd_t rand_cmd();
    stat_cmd_t c;
    int        pick;
    int        mode;
    c.op     = CMD_UNDEF;
    c.idx    = IDX_IN_W'($urandom_range(0, 127));
    c.cnt    = CNT_IN_W'($urandom_range(0, 127));
    c.amount = {$urandom, $urandom};
    pick     = $urandom_range(0, 99);
    if (pick < 30) c.op = CMD_ADD;
    else if (pick < 45) c.op = CMD_INC;
    else if (pick < 55) c.op = CMD_DEC;
    else if (pick < 70) c.op = CMD_READ;
    else if (pick < 78) c.op = CMD_CLEAR;
    else if (pick < 80) c.op = CMD_CLEAR_ALL;
    else if (pick < 96) c.op = CMD_RATE;
    if (c.op == CMD_ADD || c.op == CMD_INC || c.op == CMD_DEC) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) c.idx = IDX_IN_W'($urandom_range(0, 127));
      else if (mode <= 4) c.idx = IDX_IN_W'(pkts_sel);
      else if (mode <= 7) c.idx = IDX_IN_W'(bytes_sel);
      else c.idx = IDX_IN_W'($urandom_range(0, NCNT - 1));
      mode = $urandom_range(0, 7);
      if (mode == 1) c.amount = '1;
      else if (mode > 1) c.amount = word_t'($urandom_range(0, 2000));
    end else if (c.op == CMD_READ || c.op == CMD_CLEAR) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        c.idx = '0;
        c.cnt = CNT_IN_W'(MAX_RANGE);
      end else if (mode > 2) begin
        c.cnt = CNT_IN_W'($urandom_range(0, 8));
        c.idx = IDX_IN_W'($urandom_range(0, NCNT - int'(c.cnt)));
      end
    end
    return c;
  endfunction

  task automatic queue_cmd(input stat_cmd_t c);
    cmd_pending_q.push_back(c);
    n_queued++;
  endtask

  // Write one selector register; the block is idle whenever this is called.
  task automatic write_sel(input cfg_reg_t r, input logic [SEL_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (r == CFG_PKTS_SEL) pkts_sel = v;
    else bytes_sel = v;
  endtask

  // Hold until every queued item went in and every expected result came out.
  task automatic wait_drained();
    do @(negedge clk);
    while (n_taken != n_queued || rsp_expected_q.size() != 0);
  endtask

  // Driver: change inputs on the falling edge only. Advance to a new item once
  // the previous one was taken at the last rising edge; insert random gaps.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (cmd_pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_cmd = cmd_pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - WORD_W - CNT_IN_W - IDX_IN_W){1'b0}},
                          next_cmd.amount, next_cmd.cnt, next_cmd.idx};
        s_axis_tuser  <= next_cmd.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: sample both handshakes on the rising edge. Predict from the item
  // seen on the bus, then check any result against the oldest expectation.
  always @(posedge clk) begin
    in_fire = s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      seen_cmd.op     = s_axis_tuser;
      seen_cmd.idx    = s_axis_tdata[6:0];
      seen_cmd.cnt    = s_axis_tdata[13:7];
      seen_cmd.amount = s_axis_tdata[77:14];
      predict_counter_op(seen_cmd);
      n_taken++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      seen_rsp.status      = m_axis_tuser[0];
      seen_rsp.value_valid = m_axis_tuser[1];
      seen_rsp.index       = m_axis_tdata[5:0];
      seen_rsp.value       = m_axis_tdata[69:6];
      seen_rsp.processed   = m_axis_tdata[76:70];
      seen_rsp.pkt_rate    = m_axis_tdata[140:77];
      seen_rsp.bit_rate    = m_axis_tdata[204:141];
      seen_rsp.last        = m_axis_tlast;
      if (rsp_expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want_rsp = rsp_expected_q.pop_front();
        if (seen_rsp.status != want_rsp.status)
          report_mismatch("status", word_t'(seen_rsp.status), word_t'(want_rsp.status));
        if (seen_rsp.value_valid != want_rsp.value_valid)
          report_mismatch("value_valid", word_t'(seen_rsp.value_valid),
                          word_t'(want_rsp.value_valid));
        if (seen_rsp.index != want_rsp.index)
          report_mismatch("result_index", word_t'(seen_rsp.index), word_t'(want_rsp.index));
        if (seen_rsp.value != want_rsp.value)
          report_mismatch("counter_value", seen_rsp.value, want_rsp.value);
        if (seen_rsp.processed != want_rsp.processed)
          report_mismatch("processed_count", word_t'(seen_rsp.processed),
                          word_t'(want_rsp.processed));
        if (seen_rsp.pkt_rate != want_rsp.pkt_rate)
          report_mismatch("packet_rate", seen_rsp.pkt_rate, want_rsp.pkt_rate);
        if (seen_rsp.bit_rate != want_rsp.bit_rate)
          report_mismatch("bit_rate", seen_rsp.bit_rate, want_rsp.bit_rate);
        if (seen_rsp.last != want_rsp.last)
          report_mismatch("last", word_t'(seen_rsp.last), word_t'(want_rsp.last));
      end
      n_results++;
    end
  end

  // Watchdog: drop the run if it hangs anywhere.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (counter_mirror[k]) counter_mirror[k] = '0;
    pkt_snap  = '0;
    byte_snap = '0;
    pkt_rate  = '0;
    bit_rate  = '0;
    tx_idle_pct = 34;
    rx_idle_pct = 73;
    // Release reset on a falling edge; the block then sweeps its memory with
    // tready low, which the handshake absorbs.
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the selectors at their reset values (packets in 2, bytes in 3).
    // Wrap on add and inc, wrap on dec below zero.
    queue_cmd(make_cmd(CMD_ADD, 0, $urandom_range(0, 127), '1));
    queue_cmd(make_cmd(CMD_INC, 0, $urandom_range(0, 127), {$urandom, $urandom}));
    queue_cmd(make_cmd(CMD_DEC, 1, $urandom_range(0, 127), {$urandom, $urandom}));
    queue_cmd(make_cmd(CMD_ADD, NCNT - 1, 0, 64'h8000_0000_0000_0001));
    // Single-counter index past the bank.
    queue_cmd(make_cmd(CMD_ADD, NCNT, 5, 64'd1));
    queue_cmd(make_cmd(CMD_INC, 127, 127, '1));
    queue_cmd(make_cmd(CMD_DEC, 100, 3, '0));
    // Both counts grow, then only packets, then a byte delta whose bit count wraps,
    // then nothing grows.
    queue_cmd(make_cmd(CMD_ADD, 2, 0, 64'd1000));
    queue_cmd(make_cmd(CMD_ADD, 3, 0, 64'd5000));
    queue_cmd(make_cmd(CMD_RATE, 0, 0, '0));
    queue_cmd(make_cmd(CMD_ADD, 2, 0, 64'd55));
    queue_cmd(make_cmd(CMD_RATE, 127, 127, '1));
    queue_cmd(make_cmd(CMD_ADD, 3, 0, 64'hF000_0000_0000_0000));
    queue_cmd(make_cmd(CMD_ADD, 2, 0, 64'd20));
    queue_cmd(make_cmd(CMD_RATE, 0, 0, '0));
    queue_cmd(make_cmd(CMD_RATE, 0, 0, '0));
    // Range reads: whole bank, empty, last counter, and three out of bounds.
    queue_cmd(make_cmd(CMD_READ, 0, MAX_RANGE, '0));
    queue_cmd(make_cmd(CMD_READ, 10, 0, '1));
    queue_cmd(make_cmd(CMD_READ, NCNT - 1, 1, '0));
    queue_cmd(make_cmd(CMD_READ, 60, 5, '0));
    queue_cmd(make_cmd(CMD_READ, 0, MAX_RANGE + 1, '0));
    queue_cmd(make_cmd(CMD_READ, 127, 127, '1));
    // Range clears: top two, empty, and out of bounds.
    queue_cmd(make_cmd(CMD_CLEAR, NCNT - 2, 2, '0));
    queue_cmd(make_cmd(CMD_CLEAR, 5, 0, '0));
    queue_cmd(make_cmd(CMD_CLEAR, 1, MAX_RANGE, '0));
    queue_cmd(make_cmd(CMD_UNDEF, 0, 0, '0));
    // Clear everything, then a rate update sees both counts fall.
    queue_cmd(make_cmd(CMD_CLEAR_ALL, 127, 127, '1));
    queue_cmd(make_cmd(CMD_RATE, 0, 0, '0));
    wait_drained();

    // Random phase one: selectors at the extremes, sender idles less than receiver.
    write_sel(CFG_PKTS_SEL, '0);
    write_sel(CFG_BYTES_SEL, '1);
    repeat (ITEMS_PER_PHASE) queue_cmd(rand_cmd());
    wait_drained();

    // Random phase two: selectors swapped, idle ratios swapped.
    tx_idle_pct = 73;
    rx_idle_pct = 34;
    write_sel(CFG_PKTS_SEL, '1);
    write_sel(CFG_BYTES_SEL, '0);
    repeat (ITEMS_PER_PHASE) queue_cmd(rand_cmd());
    wait_drained();

    // Random phase three: random selectors, no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_sel(CFG_PKTS_SEL, SEL_W'($urandom_range(0, NCNT - 1)));
    write_sel(CFG_BYTES_SEL, SEL_W'($urandom_range(0, NCNT - 1)));
    repeat (ITEMS_PER_PHASE) queue_cmd(rand_cmd());
    wait_drained();

    // Catch any stray result the block might still emit.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/scmb_pkg.sv
hw/rtl/scmb_ram.sv
hw/rtl/scmb_div10.sv
hw/rtl/statistics_counter_bank_core.sv
tb/tb_statistics_counter_bank_core.sv
